/* sv/plateau_mode_detector_assert.svh */
// ---------------------------------------------------------------------------
// plateau mode detector assertion macros
// concurrent check helpers, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef PLATEAU_MODE_DETECTOR_ASSERT_SVH
`define PLATEAU_MODE_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition must hold at every clock edge out of reset
`define PMD_CHECK(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("pmd check failed");

// antecedent implies consequent in the same cycle
`define PMD_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pmd implication failed");

`else

`define PMD_CHECK(label, cond)
`define PMD_IMPLIES(label, ante, cons)

`endif

`endif

/* sv/pmd_pkg.sv */
// ---------------------------------------------------------------------------
// pmd_pkg
// shared constants and types of the plateau mode detector
// ---------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MODE_DEPTH   = 64;
  localparam int COUNT_WIDTH  = 7;
  localparam int RUN_WIDTH    = 32;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_ADDR_W   = 2;
  localparam int LIMIT_WIDTH  = 6;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_RUN   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_MODES = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_MODES = 2'd2;

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  // lookup token walking down the mode chain
  typedef struct packed {
    logic    valid;
    logic    hit;
    sample_t value;
  } query_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage

`default_nettype wire

/* sv/pmd_cell.sv */
// ---------------------------------------------------------------------------
// pmd_cell
// one stored mode; compares the passing lookup token and hands it on
// ---------------------------------------------------------------------------
`default_nettype none

module pmd_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pmd_pkg::query_t   q_in,
  output pmd_pkg::query_t        q_out,
  input  wire logic              live,
  input  wire logic              wr_en,
  input  wire pmd_pkg::sample_t  wr_data
);

  pmd_pkg::sample_t entry;
  logic             match;

  assign match = q_in.valid && live && (entry == q_in.value);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_in.valid;
    end
    q_out.value <= q_in.value;
    q_out.hit   <= q_in.hit | match;
  end

endmodule

`default_nettype wire

/* sv/plateau_mode_detector.sv */
// ---------------------------------------------------------------------------
// plateau_mode_detector
// median-of-three filter, plateau run counter and a chain of mode cells
// ---------------------------------------------------------------------------
//  channel   dir  request fields (low bit first)
//  s_*       in   tdata: sample[15:0]; tlast: is_last
//  m_*       out  tdata: verdict, mode_count[5:0], stopped_early
//  cfg_*     in   cfg_addr selects register, cfg_wdata[31:0] value
//
//  samples are taken while the block is idle; when a long enough plateau
//  ends on a nonzero value the lookup token walks all 64 mode cells, cell
//  by cell, and no sample is taken until it has left the last cell
//  the result sits in an output register; a last sample is only taken
//  once that register is free or being emptied
//  rst is synchronous; entries of the mode cells are not cleared
// ---------------------------------------------------------------------------
`default_nettype none

module plateau_mode_detector (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [15:0]                      s_tdata,   // sample
  input  wire logic                             s_tlast,   // is_last
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [7:0]                            m_tdata,   // verdict, mode_count[5:0], stopped_early
  input  wire logic                             cfg_wen,
  input  wire logic [pmd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [pmd_pkg::CFG_WIDTH-1:0]    cfg_wdata
);

  localparam int CW = pmd_pkg::COUNT_WIDTH;

  pmd_pkg::state_t  state, state_next;

  logic [pmd_pkg::RUN_WIDTH-1:0]   min_run;
  logic [pmd_pkg::LIMIT_WIDTH-1:0] min_modes;
  logic [pmd_pkg::LIMIT_WIDTH-1:0] max_modes;

  pmd_pkg::sample_t win0, win1, prev;
  logic [pmd_pkg::RUN_WIDTH-1:0] run_cnt;
  logic [CW-1:0]                 modes_found;
  logic [1:0]                    idx;
  logic                          halted;
  logic                          pend_last;

  logic                               out_valid;
  logic                               out_verdict;
  logic [pmd_pkg::LIMIT_WIDTH-1:0]    out_count;
  logic                               out_stopped;

  pmd_pkg::query_t chain [0:pmd_pkg::MODE_DEPTH];
  pmd_pkg::query_t tail;

  logic             accept;
  pmd_pkg::sample_t x;
  pmd_pkg::sample_t filt;
  logic             active;
  logic             same;
  logic             need_search;
  logic             halted_acc;
  logic             done;
  logic [CW-1:0]    new_count;
  logic             halt_fin;
  logic             emit_acc;
  logic             emit_fin;
  logic             clear_rec;
  logic             store_new;

  function automatic pmd_pkg::sample_t median3(pmd_pkg::sample_t a, pmd_pkg::sample_t b,
                                               pmd_pkg::sample_t c);
    pmd_pkg::sample_t m;
    if (a <= b && a <= c) begin
      m = (b <= c) ? b : c;
    end else if (b <= a && b <= c) begin
      m = (a <= c) ? a : c;
    end else begin
      m = (a <= b) ? a : b;
    end
    return m;
  endfunction

  function automatic logic [pmd_pkg::LIMIT_WIDTH-1:0] sat_count(logic [CW-1:0] n);
    return (n > CW'(63)) ? pmd_pkg::LIMIT_WIDTH'(63) : n[pmd_pkg::LIMIT_WIDTH-1:0];
  endfunction

  // request handshakes
  assign s_tready = (state == pmd_pkg::ST_IDLE) && (!out_valid || m_tready || !s_tlast);
  assign accept   = s_tvalid && s_tready;

  assign x           = s_tdata[pmd_pkg::SAMPLE_WIDTH-1:0];
  assign filt        = median3(win0, win1, x);
  assign active      = accept && !halted && (idx == 2'd3);
  assign same        = (filt == prev);
  // zero counts as already known, so it never needs a walk
  assign need_search = active && !same && (run_cnt >= min_run) &&
                       (prev != pmd_pkg::SAMPLE_WIDTH'(0));
  assign halted_acc  = halted | (active && (modes_found > CW'(max_modes)));

  assign tail      = chain[pmd_pkg::MODE_DEPTH];
  assign done      = (state == pmd_pkg::ST_SEARCH) && tail.valid;
  assign new_count = (!tail.hit && (modes_found != {CW{1'b1}})) ?
                     modes_found + CW'(1) : modes_found;
  assign halt_fin  = halted | (new_count > CW'(max_modes));
  assign store_new = done && !tail.hit && (modes_found < CW'(pmd_pkg::MODE_DEPTH));

  assign emit_acc  = accept && s_tlast && !need_search;
  assign emit_fin  = done && pend_last;
  assign clear_rec = emit_acc || emit_fin;

  // lookup token enters the first cell as the plateau ends
  assign chain[0].valid = need_search;
  assign chain[0].hit   = 1'b0;
  assign chain[0].value = prev;

  for (genvar i = 0; i < pmd_pkg::MODE_DEPTH; i++) begin : g_cell
    pmd_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .q_in    (chain[i]),
      .q_out   (chain[i+1]),
      .live    (modes_found > CW'(i)),
      .wr_en   (store_new && (modes_found == CW'(i))),
      .wr_data (tail.value)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pmd_pkg::ST_IDLE: begin
        if (need_search) begin
          state_next = pmd_pkg::ST_SEARCH;
        end
      end
      pmd_pkg::ST_SEARCH: begin
        if (tail.valid) begin
          state_next = pmd_pkg::ST_IDLE;
        end
      end
      default: state_next = pmd_pkg::ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_run   <= pmd_pkg::RUN_WIDTH'(100);
      min_modes <= pmd_pkg::LIMIT_WIDTH'(3);
      max_modes <= pmd_pkg::LIMIT_WIDTH'(17);
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        pmd_pkg::REG_MIN_RUN:   min_run   <= cfg_wdata[pmd_pkg::RUN_WIDTH-1:0];
        pmd_pkg::REG_MIN_MODES: min_modes <= cfg_wdata[pmd_pkg::LIMIT_WIDTH-1:0];
        pmd_pkg::REG_MAX_MODES: max_modes <= cfg_wdata[pmd_pkg::LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // record state
  always_ff @(posedge clk) begin
    if (rst || clear_rec) begin
      win0        <= '0;
      win1        <= '0;
      prev        <= '0;
      run_cnt     <= '0;
      modes_found <= '0;
      idx         <= '0;
      halted      <= 1'b0;
      pend_last   <= 1'b0;
    end else if (done) begin
      modes_found <= new_count;
      halted      <= halt_fin;
    end else if (accept) begin
      pend_last <= s_tlast;
      if (idx != 2'd3) begin
        idx <= idx + 2'd1;
      end
      if (!halted) begin
        win0 <= win1;
        win1 <= x;
        if (idx == 2'd0) begin
          prev <= x;
        end else if (idx == 2'd3) begin
          prev <= filt;
          if (same) begin
            if (run_cnt != {pmd_pkg::RUN_WIDTH{1'b1}}) begin
              run_cnt <= run_cnt + pmd_pkg::RUN_WIDTH'(1);
            end
          end else begin
            run_cnt <= '0;
          end
        end
      end
      // a walk defers the halt check until the count is settled
      if (!need_search) begin
        halted <= halted_acc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (clear_rec) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (emit_fin) begin
      out_verdict <= (new_count > CW'(min_modes)) && (new_count < CW'(max_modes));
      out_count   <= sat_count(new_count);
      out_stopped <= halt_fin;
    end else if (emit_acc) begin
      out_verdict <= (modes_found > CW'(min_modes)) && (modes_found < CW'(max_modes));
      out_count   <= sat_count(modes_found);
      out_stopped <= halted_acc;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_stopped, out_count, out_verdict};

  `include "plateau_mode_detector_assert.svh"

  `PMD_IMPLIES(a_no_take_in_search, state == pmd_pkg::ST_SEARCH, !s_tready)
  `PMD_IMPLIES(a_tail_only_in_search, tail.valid, state == pmd_pkg::ST_SEARCH)
  `PMD_IMPLIES(a_last_finds_free_slot, accept && s_tlast && out_valid, m_tready)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the plateau mode detector: a queue-fed sample
// driver and a report monitor, both with random idling, checked against a
// cycle-free model of the filter, the run counter and the mode list
// ---------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TARGET_ITEMS = 1950;
  localparam int SETTLE_WAIT  = 80;
  localparam int HOLD_CYCLES  = 1500;

  typedef struct packed {
    pmd_pkg::sample_t value;
    logic             tail;
  } sample_req_t;

  typedef struct packed {
    logic       stopped;
    logic [5:0] count;
    logic       verdict;
  } report_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        cfg_wen   = 1'b0;
  logic [1:0]  cfg_addr  = pmd_pkg::REG_MIN_RUN;
  logic [31:0] cfg_wdata = '0;

  plateau_mode_detector i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // register copies seen by the model
  logic [31:0] cfg_min_run   = 32'd100;
  int          cfg_min_modes = 3;
  int          cfg_max_modes = 17;

  // model state of the current record
  pmd_pkg::sample_t win_a        = '0;
  pmd_pkg::sample_t win_b        = '0;
  pmd_pkg::sample_t last_level   = '0;
  logic [31:0]      pair_run     = '0;
  pmd_pkg::sample_t level_store [pmd_pkg::MODE_DEPTH];
  int               levels_found = 0;
  int               rec_pos      = 0;
  logic             search_off   = 1'b0;

  sample_req_t pending_samples[$];
  report_t     reports_due[$];
  int          items_queued  = 0;
  int          errors        = 0;
  int          reports_seen  = 0;
  int          cycle_count   = 0;
  int          send_gap      = 0;
  int          send_calm     = 0;
  int          recv_wait     = 0;
  int          recv_calm     = 0;
  logic        hold_on       = 1'b0;

  function automatic pmd_pkg::sample_t mid_of_three(input pmd_pkg::sample_t a,
                                                    input pmd_pkg::sample_t b,
                                                    input pmd_pkg::sample_t c);
    if (a <= b && a <= c) return (b <= c) ? b : c;
    if (b <= a && b <= c) return (a <= c) ? a : c;
    return (a <= b) ? a : b;
  endfunction

  function automatic logic level_known(input pmd_pkg::sample_t v);
    int lim;
    lim = (levels_found < pmd_pkg::MODE_DEPTH) ? levels_found : pmd_pkg::MODE_DEPTH;
    if (v == '0) return 1'b1;
    for (int k = 0; k < lim; k++) begin
      if (level_store[k] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void fold_level(input pmd_pkg::sample_t f);
    if (f == last_level) begin
      if (pair_run != 32'hFFFF_FFFF) pair_run++;
    end else begin
      if (pair_run >= cfg_min_run && !level_known(last_level)) begin
        if (levels_found < pmd_pkg::MODE_DEPTH) level_store[levels_found] = last_level;
        if (levels_found < 127) levels_found++;
      end
      pair_run = '0;
    end
    last_level = f;
    if (levels_found > cfg_max_modes) search_off = 1'b1;
  endfunction

  function automatic void take_sample(input sample_req_t req);
    report_t r;
    if (!search_off) begin
      if (rec_pos == 0) last_level = req.value;
      else if (rec_pos >= 3) fold_level(mid_of_three(win_a, win_b, req.value));
      win_a = win_b;
      win_b = req.value;
    end
    if (rec_pos < 3) rec_pos++;
    if (req.tail) begin
      r.verdict = (levels_found > cfg_min_modes) && (levels_found < cfg_max_modes);
      r.count   = (levels_found > 63) ? 6'd63 : 6'(levels_found);
      r.stopped = search_off;
      reports_due.push_back(r);
      win_a        = '0;
      win_b        = '0;
      last_level   = '0;
      pair_run     = '0;
      levels_found = 0;
      rec_pos      = 0;
      search_off   = 1'b0;
    end
  endfunction

  // mostly short gaps, a few long ones, now and then a calm stretch
  function automatic int idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(40, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_sample(pending_samples.pop_front());
        send_gap = idle_len(send_calm);
      end
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples[0].value;
          s_tlast  <= pending_samples[0].tail;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long hold-off so the block fills and backs up its input
  initial begin
    wait (reports_seen >= 3);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
    wait (reports_seen >= 30);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // report monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reports_due.size() == 0) begin
          if (errors < 10) $display("unexpected report %h", m_tdata);
          errors++;
        end else begin
          report_t want;
          want = reports_due.pop_front();
          if (m_tdata[0] !== want.verdict || m_tdata[6:1] !== want.count ||
              m_tdata[7] !== want.stopped) begin
            if (errors < 10)
              $display("report mismatch: verdict %b/%b count %0d/%0d stopped %b/%b",
                       want.verdict, m_tdata[0], want.count, m_tdata[6:1],
                       want.stopped, m_tdata[7]);
            errors++;
          end
        end
        reports_seen++;
      end
      if (hold_on) begin
        m_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_wait = idle_len(recv_calm);
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      pmd_pkg::REG_MIN_RUN:   cfg_min_run = val;
      pmd_pkg::REG_MIN_MODES: cfg_min_modes = int'(val[5:0]);
      pmd_pkg::REG_MAX_MODES: cfg_max_modes = int'(val[5:0]);
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk, only the low six count
  task automatic apply_setup(input logic [31:0] min_run, input int min_modes,
                             input int max_modes);
    write_reg(pmd_pkg::REG_MIN_RUN, min_run);
    write_reg(pmd_pkg::REG_MIN_MODES, {26'($urandom), 6'(min_modes)});
    write_reg(pmd_pkg::REG_MAX_MODES, {26'($urandom), 6'(max_modes)});
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic queue_sample(input pmd_pkg::sample_t v, input logic tail);
    sample_req_t req;
    req.value = v;
    req.tail  = tail;
    pending_samples.push_back(req);
    items_queued++;
  endtask

  function automatic pmd_pkg::sample_t pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    if (r < 5) return pmd_pkg::sample_t'($urandom_range(1, 7));
    return pmd_pkg::sample_t'($urandom);
  endfunction

  // runs of levels from a small pool so that known modes recur
  task automatic queue_plateaus(input int levels, input int run_hi);
    pmd_pkg::sample_t pool [6];
    pmd_pkg::sample_t v;
    int               n;
    for (int k = 0; k < 6; k++) pool[k] = pick_level();
    for (int k = 0; k < levels; k++) begin
      v = pool[$urandom_range(0, 5)];
      n = $urandom_range(1, run_hi);
      for (int j = 0; j < n; j++) begin
        // a lone spike that the median should swallow
        if (n > 3 && j == n / 2 && $urandom_range(0, 4) == 0)
          queue_sample(pmd_pkg::sample_t'($urandom), 1'b0);
        else
          queue_sample(v, 1'b0);
      end
    end
    queue_sample(pick_level(), 1'b1);
  endtask

  task automatic queue_noise(input int len, input logic narrow);
    for (int k = 0; k < len; k++)
      queue_sample(narrow ? pmd_pkg::sample_t'($urandom_range(0, 3)) :
                            pmd_pkg::sample_t'($urandom),
                   k == len - 1);
  endtask

  task automatic queue_run(input pmd_pkg::sample_t v, input int n);
    for (int k = 0; k < n; k++) queue_sample(v, 1'b0);
  endtask

  initial begin
    int          nrec;
    int          pick;
    int          run_hi;
    logic [31:0] min_run;
    int          min_modes;
    int          max_modes;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: long plateaus against the default run length
    queue_run(16'h1234, 105);
    queue_run(16'hFFFF, 98);
    queue_run(16'h1234, 104);
    queue_sample(16'h0001, 1'b1);
    settle();

    // short records, zero plateau, repeated level, spike and halt
    apply_setup(32'd1, 0, 1);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'h0000, 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_sample(16'h8000, 1'b0);
    queue_sample(16'h7FFF, 1'b0);
    queue_sample(16'h0001, 1'b1);
    queue_run(16'h0005, 3);
    queue_sample(16'h0005, 1'b1);
    queue_run(16'h0009, 3);
    queue_run(16'h0000, 3);
    queue_sample(16'hFFFF, 1'b0);
    queue_run(16'h0009, 3);
    queue_run(16'h0003, 3);
    queue_sample(16'h0006, 1'b1);
    settle();

    // full mode list, count beyond the report field
    apply_setup(32'd0, 62, 63);
    for (int k = 1; k <= 72; k++) queue_sample(pmd_pkg::sample_t'(k * 911), 1'b0);
    queue_sample(16'hFFFF, 1'b1);
    queue_plateaus(6, 4);
    settle();

    // no plateau can ever be long enough
    apply_setup(32'hFFFF_FFFF, 63, 0);
    queue_plateaus(8, 6);
    queue_noise(12, 1'b1);
    settle();

    while (items_queued < TARGET_ITEMS) begin
      pick = $urandom_range(0, 9);
      min_run   = (pick == 0) ? 32'd0 : 32'($urandom_range(0, 6));
      min_modes = (pick == 1) ? 63 : (pick == 2) ? 0 : $urandom_range(0, 6);
      max_modes = (pick == 3) ? 0 : (pick == 4) ? 63 : $urandom_range(1, 12);
      apply_setup(min_run, min_modes, max_modes);
      run_hi = int'(min_run) + 4;
      nrec   = $urandom_range(2, 6);
      for (int r = 0; r < nrec; r++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)
          queue_plateaus($urandom_range(1, 10), run_hi);
        else if (pick < 17)
          queue_noise($urandom_range(5, 25), pick[0]);
        else
          queue_noise($urandom_range(1, 4), 1'b0);
      end
      settle();
    end

    settle();
    if (errors == 0 && reports_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
